// File: hw/rtl/calendar_date_advance_defines.svh
// ----------------------------------------------------------------------------
// Calendar date advance assertion macros
// Shared assertion forms for the calendar date block, sampled on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADVANCE_DEFINES_SVH
`define CALENDAR_DATE_ADVANCE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_date_advance: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_date_advance: next-cycle check failed");

`endif

// File: hw/rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date advance package
// Command codes, divider control types, calendar constants and the month
// length function shared by the block's modules.
// ----------------------------------------------------------------------------
package cda_pkg;

    // year register width and reset date
    localparam int YEAR_WIDTH_DEFAULT = 16;
    localparam int RESET_YEAR         = 2000;
    localparam int RESET_MONTH        = 1;
    localparam int RESET_DAY          = 1;

    // payload widths
    localparam int CMD_WIDTH    = 2;
    localparam int PORT_YEAR_W  = 16;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int AMOUNT_W     = 16;
    // day position during a walk: day plus amount
    localparam int POS_W        = 17;
    // divider remainder width (remainders below 25)
    localparam int REM_W        = 5;

    // divisors used by the shared divide unit
    localparam int MONTHS_PER_YEAR = 12;
    // year mod 25 together with year mod 16 settles the century rules
    localparam int CENTURY_FACTOR  = 25;

    localparam int LAST_MONTH = 12;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_SET        = 2'd0,
        CMD_ADD_DAYS   = 2'd1,
        CMD_ADD_MONTHS = 2'd2,
        CMD_ADD_YEARS  = 2'd3
    } cmd_t;

    typedef enum logic {
        DIV_BY_MONTHS  = 1'b0,
        DIV_BY_CENTURY = 1'b1
    } div_sel_t;

    // request from the sequencer to the divide unit
    typedef struct packed {
        logic     start;
        div_sel_t sel;
    } div_req_t;

    // status from the divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    // days in a month, month 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd2:                     len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
                default:                  len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: hw/rtl/cda_if.sv
// ----------------------------------------------------------------------------
// Calendar date advance channel interfaces
// Valid/ready channels for command items and for result date items.
// ----------------------------------------------------------------------------

// command channel
interface cda_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] amount;

    modport source (output valid, output command, output new_year, output new_month,
                    output new_day, output amount, input ready);
    modport sink   (input valid, input command, input new_year, input new_month,
                    input new_day, input amount, output ready);
endinterface

// result date channel
interface cda_date_if;
    logic        valid;
    logic        ready;
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;

    modport source (output valid, output cur_year, output cur_month, output cur_day,
                    input ready);
    modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                    output ready);
endinterface

// File: hw/rtl/cda_divider.sv
// ----------------------------------------------------------------------------
// Calendar date advance divide unit
// Divides by a small constant (12 or 25) through reciprocal multiplication
// in order: load, multiply, remainder. Shared by the month carry
// and the year residue used in the leap test.
// ----------------------------------------------------------------------------
module cda_divider #(
    parameter int DIVIDEND_WIDTH = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cda_pkg::div_req_t             req,
    input  logic [DIVIDEND_WIDTH-1:0]     dividend,
    output cda_pkg::div_rsp_t             rsp,
    output logic [DIVIDEND_WIDTH-1:0]     quotient,
    output logic [cda_pkg::REM_W-1:0]     remainder
);

    // operand width of the reciprocal multiply
    localparam int NUM_W  = 20;
    localparam int PROD_W = 2 * NUM_W;
    // ceil(2^19 / 12): exact quotients for operands below 2^17
    localparam int RECIP_MONTHS  = 43691;
    localparam int SHIFT_MONTHS  = 19;
    // ceil(2^24 / 25): exact quotients for operands below 2^20
    localparam int RECIP_CENTURY = 671089;
    localparam int SHIFT_CENTURY = 24;
    // 2^16 mod 25, folds the upper year bits onto the low 16
    localparam int FOLD_CENTURY  = 11;
    localparam int FOLD_SHIFT    = 16;

    logic                        mul_reg,   mul_next;
    logic                        sub_reg,   sub_next;
    logic                        done_reg,  done_next;
    cda_pkg::div_sel_t           sel_reg,   sel_next;
    logic [NUM_W-1:0]            num_reg,   num_next;
    logic [NUM_W-1:0]            quo_reg,   quo_next;
    logic [cda_pkg::REM_W-1:0]   rem_reg,   rem_next;

    logic [DIVIDEND_WIDTH-1:0]   upper;
    logic [NUM_W-1:0]            folded;
    logic [NUM_W-1:0]            recip;
    logic [NUM_W-1:0]            divisor;
    logic [PROD_W-1:0]           product;
    logic [NUM_W-1:0]            quo_calc;

    // year mod 25 is kept when the bits above bit 15 are folded down
    assign upper  = dividend >> FOLD_SHIFT;
    assign folded = NUM_W'(dividend[FOLD_SHIFT-1:0])
                  + NUM_W'(upper) * NUM_W'(FOLD_CENTURY);

    // reciprocal and divisor of the job in flight
    always_comb
    begin
        case (sel_reg)
            cda_pkg::DIV_BY_MONTHS:
            begin
                recip   = NUM_W'(RECIP_MONTHS);
                divisor = NUM_W'(cda_pkg::MONTHS_PER_YEAR);
            end
            cda_pkg::DIV_BY_CENTURY:
            begin
                recip   = NUM_W'(RECIP_CENTURY);
                divisor = NUM_W'(cda_pkg::CENTURY_FACTOR);
            end
            default:
            begin
                recip   = NUM_W'(RECIP_MONTHS);
                divisor = NUM_W'(cda_pkg::MONTHS_PER_YEAR);
            end
        endcase
    end

    // quotient by reciprocal multiplication
    assign product = PROD_W'(num_reg) * PROD_W'(recip);

    always_comb
    begin
        case (sel_reg)
            cda_pkg::DIV_BY_MONTHS:  quo_calc = NUM_W'(product >> SHIFT_MONTHS);
            cda_pkg::DIV_BY_CENTURY: quo_calc = NUM_W'(product >> SHIFT_CENTURY);
            default:                 quo_calc = NUM_W'(product >> SHIFT_MONTHS);
        endcase
    end

    // load, multiply, then remainder
    always_comb
    begin
        mul_next  = req.start;
        sub_next  = mul_reg;
        done_next = sub_reg;
        sel_next  = sel_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            sel_next = req.sel;
            if (req.sel == cda_pkg::DIV_BY_CENTURY)
                num_next = folded;
            else
                num_next = NUM_W'(dividend);
        end
        if (mul_reg)
            quo_next = quo_calc;
        if (sub_reg)
            rem_next = cda_pkg::REM_W'(num_reg - quo_reg * divisor);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy  = mul_reg | sub_reg;
    assign rsp.done  = done_reg;
    assign quotient  = DIVIDEND_WIDTH'(quo_reg);
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/calendar_date_advance.sv
// ----------------------------------------------------------------------------
// Calendar date advance
// Gregorian date register (year, month, day) driven by set, add days, add
// months and add years commands; each command returns the resulting date.
// ----------------------------------------------------------------------------
// One command item is taken at a time; cmd.ready is high only while the
// sequencer is idle, and a finished date waits in the output register so the
// next command can be taken before it is read. Set and add years go straight
// to the done state; add months and add days go through the shared divide
// unit, which multiplies by a reciprocal to carry months into years (divide
// by 12) or to form year mod 25 for the leap test before a day walk. The day
// walk steps one month per cycle. A command that finishes while the previous
// date is still unread waits until that date is taken. Years wrap at
// YEAR_WIDTH bits; the result year shows the low 16 bits of the year
// register.
module calendar_date_advance #(
    parameter int YEAR_WIDTH = cda_pkg::YEAR_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    cda_cmd_if.sink           cmd,
    cda_date_if.source        result
);

    localparam int DW = (YEAR_WIDTH > cda_pkg::POS_W) ? YEAR_WIDTH : cda_pkg::POS_W;
    localparam int MW = cda_pkg::MONTH_W;
    localparam int PW = cda_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [YEAR_WIDTH-1:0]       year_reg,  year_next;
    logic [MW-1:0]               month_reg, month_next;
    logic [cda_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic                        out_valid_reg, out_valid_next;

    cda_pkg::cmd_t               op_reg,    op_next;
    logic [PW-1:0]               pos_reg,   pos_next;
    logic [cda_pkg::REM_W-1:0]   res_reg,   res_next;
    logic [cda_pkg::PORT_YEAR_W-1:0] cur_year_reg;
    logic [MW-1:0]               cur_month_reg;
    logic [cda_pkg::DAY_W-1:0]   cur_day_reg;

    cda_pkg::cmd_t               cmd_code;
    cda_pkg::div_req_t           div_req;
    cda_pkg::div_rsp_t           div_rsp;
    logic [DW-1:0]               div_dividend;
    logic [DW-1:0]               div_quotient;
    logic [cda_pkg::REM_W-1:0]   div_remainder;

    logic                        cmd_fire;
    logic                        out_load;
    logic [MW-1:0]               month_fixed;
    logic                        leap;
    logic [cda_pkg::DAY_W-1:0]   len;
    logic [cda_pkg::REM_W-1:0]   res_inc;

    assign cmd_code  = cda_pkg::cmd_t'(cmd.command);
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // out-of-range month clamped before add days and add months
    always_comb
    begin
        if (month_reg == MW'(0))
            month_fixed = MW'(1);
        else if (month_reg > MW'(cda_pkg::LAST_MONTH))
            month_fixed = MW'(cda_pkg::LAST_MONTH);
        else
            month_fixed = month_reg;
    end

    // leap test from low year bits and year mod 25
    assign leap = ((year_reg[1:0] == 2'd0) && (res_reg != '0))
               || ((year_reg[3:0] == 4'd0) && (res_reg == '0));
    assign len  = cda_pkg::month_len(month_reg, leap);

    // residue of the following year, wrap to zero restarts it
    always_comb
    begin
        if (&year_reg)
            res_inc = '0;
        else if (res_reg == cda_pkg::REM_W'(cda_pkg::CENTURY_FACTOR - 1))
            res_inc = '0;
        else
            res_inc = res_reg + cda_pkg::REM_W'(1);
    end

    // divider request
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.sel   = cda_pkg::DIV_BY_MONTHS;
        div_dividend  = DW'(year_reg);
        if (cmd_fire && (cmd_code == cda_pkg::CMD_ADD_MONTHS))
        begin
            div_req.start = 1'b1;
            div_req.sel   = cda_pkg::DIV_BY_MONTHS;
            div_dividend  = DW'(month_fixed - MW'(1)) + DW'(cmd.amount);
        end
        else if (cmd_fire && (cmd_code == cda_pkg::CMD_ADD_DAYS))
        begin
            div_req.start = 1'b1;
            div_req.sel   = cda_pkg::DIV_BY_CENTURY;
            div_dividend  = DW'(year_reg);
        end
    end

    cda_divider #(
        .DIVIDEND_WIDTH (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .rsp       (div_rsp),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next = cmd_code;
                    case (cmd_code)
                        cda_pkg::CMD_SET:
                        begin
                            year_next  = YEAR_WIDTH'(cmd.new_year);
                            month_next = cmd.new_month;
                            day_next   = cmd.new_day;
                            state_next = S_DONE;
                        end
                        cda_pkg::CMD_ADD_DAYS:
                        begin
                            month_next = month_fixed;
                            pos_next   = PW'(day_reg) + PW'(cmd.amount);
                            state_next = S_DIV;
                        end
                        cda_pkg::CMD_ADD_MONTHS:
                        begin
                            state_next = S_DIV;
                        end
                        cda_pkg::CMD_ADD_YEARS:
                        begin
                            year_next  = year_reg + YEAR_WIDTH'(cmd.amount);
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (op_reg == cda_pkg::CMD_ADD_MONTHS)
                    begin
                        year_next  = year_reg + YEAR_WIDTH'(div_quotient);
                        month_next = MW'(div_remainder) + MW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_next   = div_remainder;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // one month per cycle until the position fits
                if (pos_reg <= PW'(len))
                begin
                    day_next   = cda_pkg::DAY_W'(pos_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = pos_reg - PW'(len);
                    if (month_reg >= MW'(cda_pkg::LAST_MONTH))
                    begin
                        month_next = MW'(1);
                        year_next  = year_reg + YEAR_WIDTH'(1);
                        res_next   = res_inc;
                    end
                    else
                    begin
                        month_next = month_reg + MW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and date state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            year_reg      <= YEAR_WIDTH'(cda_pkg::RESET_YEAR);
            month_reg     <= MW'(cda_pkg::RESET_MONTH);
            day_reg       <= cda_pkg::DAY_W'(cda_pkg::RESET_DAY);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
        if (out_load)
        begin
            cur_year_reg  <= cda_pkg::PORT_YEAR_W'(year_reg);
            cur_month_reg <= month_reg;
            cur_day_reg   <= day_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.cur_year  = cur_year_reg;
    assign result.cur_month = cur_month_reg;
    assign result.cur_day   = cur_day_reg;

`include "calendar_date_advance_defines.svh"

    // an accepted command always leaves idle
    `CDA_ASSERT_NEXT(a_fire_leaves_idle, cmd_fire, state_reg != S_IDLE)
    // the divider is never running while the sequencer is idle
    `CDA_ASSERT_SAME(a_idle_div_quiet, state_reg == S_IDLE, !div_rsp.busy && !div_rsp.done)
    // divider completion only arrives while it is awaited
    `CDA_ASSERT_SAME(a_done_in_div, div_rsp.done, state_reg == S_DIV)
    // the day walk only sees valid months
    `CDA_ASSERT_SAME(a_walk_month, state_reg == S_WALK,
                     (month_reg >= MW'(1)) && (month_reg <= MW'(cda_pkg::LAST_MONTH)))

endmodule
